FILE: sv/bitstream_reader_expgolomb_defines.svh
// Assertion macros shared by the bitstream reader RTL.
`ifndef BITSTREAM_READER_EXPGOLOMB_DEFINES_SVH
`define BITSTREAM_READER_EXPGOLOMB_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define BSR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define BSR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/bsr_pkg.sv
// Types, widths and helpers for the bitstream reader.
package bsr_pkg;

  localparam int FuncW  = 3;
  localparam int LAddrW = 12;
  localparam int DataW  = 8;
  localparam int CountW = 6;
  localparam int LenW   = 13;
  localparam int BitW   = 3;
  localparam int OffW   = 16;
  localparam int ValueW = 32;
  localparam int ClenW  = 6;
  localparam int StatW  = 2;
  localparam int PosW   = LenW + BitW;

  typedef enum logic [FuncW-1:0] {
    FN_LOAD    = 3'd0,
    FN_READ    = 3'd1,
    FN_PEEK    = 3'd2,
    FN_READ_UE = 3'd3,
    FN_PEEK_UE = 3'd4,
    FN_SEEK    = 3'd5,
    FN_SKIP    = 3'd6
  } func_e;

  typedef enum logic [StatW-1:0] {
    ST_OK  = 2'd0,
    ST_END = 2'd1,
    ST_BAD = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FETCH,
    S_SCAN,
    S_FINISH
  } state_e;

  // Leading zeros of a byte, MSB first; 8 when the byte is zero.
  function automatic logic [3:0] clz8(logic [7:0] b);
    logic [3:0] n;
    logic       hit;
    n   = 4'd8;
    hit = 1'b0;
    for (int i = 7; i >= 0; i--) begin
      if (!hit && b[i]) begin
        n   = 4'(7 - i);
        hit = 1'b1;
      end
    end
    return n;
  endfunction

endpackage

FILE: sv/bsr_ram.sv
// Generic single-port RAM with registered read data.
module bsr_ram #(
  parameter int Width = 8,
  parameter int Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/bitstream_reader_expgolomb.sv
// Bitstream reader: byte buffer, bit read position and unsigned exp-Golomb decode.
//
// Usage: drive func_i and its operand ports with start high; the command is
// taken on a rising edge where start is high and busy is low. Every command
// gives exactly one result transfer: done_o is high for one cycle with
// value_o, code_length_o, status_o and the new position on the result ports.
// The receiver cannot stall; a result is gone after its one cycle.
// Flow: load, seek, skip, zero-bit reads and any request rejected up front
// finish from idle, with the result the cycle after acceptance; busy stays
// low, so one such command can be issued every cycle. A bit read of n bits at
// bit offset b fetches k = ceil((b+n)/8) bytes, up to 5, in the fetch state,
// then forms the value in the finish state. A ue code scans one byte per cycle
// until its first one bit (up to 5 bytes), then fetches the suffix bytes the
// same way. The single buffer port reads one byte per cycle.
// Reset: position goes to zero, stream_length to zero; buffer contents are
// undefined until loaded. stream_length is written via cfg_we_i/cfg_wdata_i;
// the user must write it only while the block is idle; the block does not enforce it.

`include "bitstream_reader_expgolomb_defines.svh"

module bitstream_reader_expgolomb #(
  parameter int BUFFER_BYTES  = 4096,
  parameter int MAX_READ_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bsr_pkg::LenW-1:0]      cfg_wdata_i,
  input  logic                          start,
  output logic                          busy,
  input  logic [bsr_pkg::FuncW-1:0]     func_i,
  input  logic [bsr_pkg::LAddrW-1:0]    load_address_i,
  input  logic [bsr_pkg::DataW-1:0]     load_data_i,
  input  logic [bsr_pkg::CountW-1:0]    bit_count_i,
  input  logic [bsr_pkg::LenW-1:0]      seek_byte_i,
  input  logic [bsr_pkg::BitW-1:0]      seek_bit_i,
  input  logic signed [bsr_pkg::OffW-1:0] bit_offset_i,
  output logic                          done_o,
  output logic [bsr_pkg::ValueW-1:0]    value_o,
  output logic [bsr_pkg::ClenW-1:0]     code_length_o,
  output logic [bsr_pkg::StatW-1:0]     status_o,
  output logic [bsr_pkg::LenW-1:0]      position_byte_o,
  output logic [bsr_pkg::BitW-1:0]      position_bit_o
);
  import bsr_pkg::*;

  localparam int AW = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;
  // Longest ue prefix accepted
  localparam logic [ClenW-1:0] UeLim = ClenW'((MAX_READ_BITS < 31) ? MAX_READ_BITS : 31);
  localparam logic [CountW-1:0] MaxBits = CountW'(MAX_READ_BITS);

  state_e              state_q, state_d;
  logic [LenW-1:0]     len_q, len_eff;
  logic [PosW-1:0]     pos_q, pos_d;
  logic [PosW-1:0]     end_bits;

  // Fetch engine
  logic [LenW-1:0]     fb_q, fb_d;
  logic [2:0]          nb_q, nb_d, iss_q, iss_d, rcv_q, rcv_d, sh_q, sh_d;
  logic [CountW-1:0]   n_q, n_d;
  logic [ClenW-1:0]    z1_q, z1_d, zc_q, zc_d;
  logic                ue_q, ue_d, commit_q, commit_d, first_q, first_d;
  logic                rdv_q, rdv_d, issue;
  logic [39:0]         win_q, win_d;
  logic [PosW-1:0]     npos_q, npos_d;

  // Result registers
  logic                done_q, done_d;
  logic [ValueW-1:0]   value_q, value_d;
  logic [ClenW-1:0]    clen_q, clen_d;
  status_e             status_q, status_d;
  logic [PosW-1:0]     opos_q, opos_d;

  // RAM port
  logic                ram_we;
  logic [AW-1:0]       ram_addr;
  logic [DataW-1:0]    ram_rdata;

  // Fetch setup and scan helpers
  logic [PosW-1:0]     fx_sa;
  logic [CountW-1:0]   fx_n;
  logic [6:0]          fx_span;
  logic [2:0]          fx_nb, fx_sh;
  logic [2:0]          sc_off;
  logic [7:0]          sc_m;
  logic [3:0]          sc_lz;
  logic [ClenW-1:0]    sc_z1, sc_zc_new;
  logic [PosW-1:0]     z_end;
  logic                zend_le_lim, ran_out;
  logic [PosW:0]       seek_tgt;
  logic signed [PosW+1:0] skip_tgt;
  logic [39:0]         win_sh;
  logic [ValueW-1:0]   field_val;

  assign len_eff  = (int'(len_q) > BUFFER_BYTES) ? LenW'(BUFFER_BYTES) : len_q;
  assign end_bits = {len_eff, 3'b000};
  assign z_end    = end_bits - pos_q;
  assign zend_le_lim = (z_end <= PosW'(UeLim));

  // Leading-zero scan over the byte just returned by the RAM
  assign sc_off    = first_q ? pos_q[2:0] : 3'd0;
  assign sc_m      = ram_rdata & (8'hFF >> sc_off);
  assign sc_lz     = clz8(sc_m);
  assign sc_z1     = zc_q + ClenW'(sc_lz) - ClenW'(sc_off);
  assign sc_zc_new = zc_q + ClenW'(4'd8 - {1'b0, sc_off});
  assign ran_out   = ({1'b0, pos_q} + (PosW+1)'(sc_zc_new)) >= {1'b0, end_bits};

  // Byte span of a field: plain reads start at the position, ue suffix after the prefix
  always_comb begin
    if (state_q == S_SCAN) begin
      fx_sa = pos_q + PosW'(sc_z1) + PosW'(1);
      fx_n  = sc_z1;
    end else begin
      fx_sa = pos_q;
      fx_n  = bit_count_i;
    end
  end
  assign fx_span = 7'(fx_sa[2:0]) + 7'(fx_n) + 7'd7;
  assign fx_nb   = fx_span[5:3];
  assign fx_sh   = 3'd0 - (fx_sa[2:0] + fx_n[2:0]);

  assign seek_tgt = {1'b0, seek_byte_i, seek_bit_i};
  assign skip_tgt = $signed({2'b00, pos_q}) + $signed({{2{bit_offset_i[OffW-1]}}, bit_offset_i});

  assign win_sh    = win_q >> sh_q;
  assign field_val = win_sh[ValueW-1:0] & ValueW'((33'd1 << n_q) - 33'd1);

  always_comb begin
    state_d  = state_q;
    pos_d    = pos_q;
    fb_d     = fb_q;
    nb_d     = nb_q;
    iss_d    = iss_q;
    rcv_d    = rcv_q;
    sh_d     = sh_q;
    n_d      = n_q;
    z1_d     = z1_q;
    zc_d     = zc_q;
    ue_d     = ue_q;
    commit_d = commit_q;
    first_d  = first_q;
    win_d    = win_q;
    npos_d   = npos_q;
    done_d   = 1'b0;
    value_d  = value_q;
    clen_d   = clen_q;
    status_d = status_q;
    opos_d   = opos_q;
    ram_we   = 1'b0;
    ram_addr = AW'(fb_q);
    issue    = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          done_d   = 1'b1;
          value_d  = '0;
          clen_d   = '0;
          status_d = ST_OK;
          unique case (func_e'(func_i))
            FN_LOAD: begin
              ram_addr = AW'(load_address_i);
              ram_we   = (int'(load_address_i) < BUFFER_BYTES);
            end
            FN_READ, FN_PEEK: begin
              if (bit_count_i > MaxBits) begin
                status_d = ST_BAD;
              end else if (({1'b0, pos_q} + (PosW+1)'(bit_count_i)) > {1'b0, end_bits}) begin
                status_d = ST_END;
              end else if (bit_count_i != '0) begin
                done_d   = 1'b0;
                state_d  = S_FETCH;
                fb_d     = pos_q[PosW-1:BitW];
                nb_d     = fx_nb;
                sh_d     = fx_sh;
                n_d      = bit_count_i;
                iss_d    = '0;
                rcv_d    = '0;
                ue_d     = 1'b0;
                z1_d     = '0;
                commit_d = (func_e'(func_i) == FN_READ);
                npos_d   = pos_q + PosW'(bit_count_i);
              end
            end
            FN_READ_UE, FN_PEEK_UE: begin
              if (pos_q >= end_bits) begin
                status_d = ST_END;
              end else begin
                done_d   = 1'b0;
                state_d  = S_SCAN;
                fb_d     = pos_q[PosW-1:BitW];
                zc_d     = '0;
                first_d  = 1'b1;
                commit_d = (func_e'(func_i) == FN_READ_UE);
              end
            end
            FN_SEEK: begin
              if (seek_tgt > {1'b0, end_bits}) begin
                status_d = ST_END;
              end else begin
                pos_d = seek_tgt[PosW-1:0];
              end
            end
            FN_SKIP: begin
              if (skip_tgt < 0 || skip_tgt > $signed({2'b00, end_bits})) begin
                status_d = ST_END;
              end else begin
                pos_d = skip_tgt[PosW-1:0];
              end
            end
            default: begin
              status_d = ST_BAD;
            end
          endcase
        end
      end

      S_FETCH: begin
        if (iss_q < nb_q) begin
          issue = 1'b1;
          fb_d  = fb_q + LenW'(1);
          iss_d = iss_q + 3'd1;
        end
        if (rdv_q) begin
          win_d = {win_q[31:0], ram_rdata};
          rcv_d = rcv_q + 3'd1;
          if (rcv_q + 3'd1 == nb_q) begin
            state_d = S_FINISH;
          end
        end
      end

      S_SCAN: begin
        // Read one byte ahead while the stream lasts; a stale read is dropped on exit
        if (fb_q < len_eff) begin
          issue = 1'b1;
          fb_d  = fb_q + LenW'(1);
        end
        if (rdv_q) begin
          first_d = 1'b0;
          zc_d    = sc_zc_new;
          if (sc_m != '0) begin
            if (sc_z1 <= UeLim) begin
              if (({1'b0, pos_q} + (PosW+1)'({sc_z1, 1'b1})) > {1'b0, end_bits}) begin
                done_d   = 1'b1;
                value_d  = '0;
                clen_d   = '0;
                status_d = ST_END;
                state_d  = S_IDLE;
              end else if (sc_z1 == '0) begin
                // code "1": value zero, one bit long
                done_d   = 1'b1;
                value_d  = '0;
                clen_d   = ClenW'(1);
                status_d = ST_OK;
                pos_d    = commit_q ? pos_q + PosW'(1) : pos_q;
                state_d  = S_IDLE;
              end else begin
                state_d = S_FETCH;
                fb_d    = fx_sa[PosW-1:BitW];
                nb_d    = fx_nb;
                sh_d    = fx_sh;
                n_d     = sc_z1;
                iss_d   = '0;
                rcv_d   = '0;
                ue_d    = 1'b1;
                z1_d    = sc_z1;
                npos_d  = pos_q + PosW'({sc_z1, 1'b1});
              end
            end else begin
              done_d   = 1'b1;
              value_d  = '0;
              clen_d   = '0;
              status_d = zend_le_lim ? ST_END : ST_BAD;
              state_d  = S_IDLE;
            end
          end else if (ran_out || sc_zc_new > UeLim) begin
            done_d   = 1'b1;
            value_d  = '0;
            clen_d   = '0;
            status_d = zend_le_lim ? ST_END : ST_BAD;
            state_d  = S_IDLE;
          end
        end
      end

      S_FINISH: begin
        done_d   = 1'b1;
        status_d = ST_OK;
        if (ue_q) begin
          value_d = field_val + ((ValueW'(1) << z1_q[4:0]) - ValueW'(1));
          clen_d  = ClenW'({z1_q[4:0], 1'b1});
        end else begin
          value_d = field_val;
          clen_d  = '0;
        end
        pos_d   = commit_q ? npos_q : pos_q;
        state_d = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (issue) begin
      ram_addr = AW'(fb_q);
    end
    rdv_d = issue && (state_d == state_q);
    if (done_d) begin
      opos_d = pos_d;
    end
  end

  bsr_ram #(
    .Width(DataW),
    .Depth(BUFFER_BYTES)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(load_data_i),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pos_q   <= '0;
      len_q   <= '0;
      done_q  <= 1'b0;
      rdv_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      done_q  <= done_d;
      rdv_q   <= rdv_d;
      if (cfg_we_i) begin
        len_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    fb_q     <= fb_d;
    nb_q     <= nb_d;
    iss_q    <= iss_d;
    rcv_q    <= rcv_d;
    sh_q     <= sh_d;
    n_q      <= n_d;
    z1_q     <= z1_d;
    zc_q     <= zc_d;
    ue_q     <= ue_d;
    commit_q <= commit_d;
    first_q  <= first_d;
    win_q    <= win_d;
    npos_q   <= npos_d;
    value_q  <= value_d;
    clen_q   <= clen_d;
    status_q <= status_d;
    opos_q   <= opos_d;
  end

  assign busy            = (state_q != S_IDLE);
  assign done_o          = done_q;
  assign value_o         = value_q;
  assign code_length_o   = clen_q;
  assign status_o        = status_q;
  assign position_byte_o = opos_q[PosW-1:BitW];
  assign position_bit_o  = opos_q[BitW-1:0];

  // Checks
  `BSR_ASSERT_NOW(a_err_no_data, done_o && status_o != ST_OK, value_o == '0 && code_length_o == '0, "error result carries data")
  `BSR_ASSERT_NOW(a_clen_odd, done_o && code_length_o != '0, code_length_o[0], "even ue code length")
  `BSR_ASSERT_NEXT(a_load_one_cycle, start && !busy && func_i == FN_LOAD, done_o && !busy, "load result late")

endmodule

FILE: tb/tb.sv
// Self-checking testbench for the bitstream reader with unsigned exp-Golomb decode.
module tb;
  import bsr_pkg::*;

  // Block geometry as built with default parameters
  localparam int BUF_BYTES     = 4096;
  localparam int MAX_BITS      = 32;
  localparam int UE_ZERO_LIMIT = 31;     // longest legal ue prefix
  localparam int WINDOW_BYTES  = 9;      // 31 zeros + one bit + 31 suffix bits + bit offset
  localparam int DRAIN_CYCLES  = 20;
  localparam int PHASE_ITEMS   = 50;
  localparam int PHASES        = 8;
  localparam logic [FuncW-1:0] FN_UNUSED = 3'd7;

  typedef struct {
    logic [FuncW-1:0]       func;
    logic [LAddrW-1:0]      load_address;
    logic [DataW-1:0]       load_data;
    logic [CountW-1:0]      bit_count;
    logic [LenW-1:0]        seek_byte;
    logic [BitW-1:0]        seek_bit;
    logic signed [OffW-1:0] bit_offset;
  } cmd_t;

  typedef struct {
    logic [ValueW-1:0] value;
    logic [ClenW-1:0]  code_length;
    status_e           status;
    logic [LenW-1:0]   position_byte;
    logic [BitW-1:0]   position_bit;
  } outcome_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [LenW-1:0]        cfg_wdata_i;
  logic                   start;
  logic                   busy;
  logic [FuncW-1:0]       func_i;
  logic [LAddrW-1:0]      load_address_i;
  logic [DataW-1:0]       load_data_i;
  logic [CountW-1:0]      bit_count_i;
  logic [LenW-1:0]        seek_byte_i;
  logic [BitW-1:0]        seek_bit_i;
  logic signed [OffW-1:0] bit_offset_i;
  logic                   done_o;
  logic [ValueW-1:0]      value_o;
  logic [ClenW-1:0]       code_length_o;
  logic [StatW-1:0]       status_o;
  logic [LenW-1:0]        position_byte_o;
  logic [BitW-1:0]        position_bit_o;

  bitstream_reader_expgolomb DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .start          (start),
    .busy           (busy),
    .func_i         (func_i),
    .load_address_i (load_address_i),
    .load_data_i    (load_data_i),
    .bit_count_i    (bit_count_i),
    .seek_byte_i    (seek_byte_i),
    .seek_bit_i     (seek_bit_i),
    .bit_offset_i   (bit_offset_i),
    .done_o         (done_o),
    .value_o        (value_o),
    .code_length_o  (code_length_o),
    .status_o       (status_o),
    .position_byte_o(position_byte_o),
    .position_bit_o (position_bit_o)
  );

  // Shadow of the block: buffer contents, which bytes were loaded, the read
  // position as one bit address, and the stream_length register.
  logic [7:0]   shadow_bytes [BUF_BYTES];
  bit           byte_loaded  [BUF_BYTES];
  int unsigned  cur_pos;
  int unsigned  cur_length;

  outcome_t     expected_outcomes [$];
  outcome_t     oldest;
  int unsigned  mismatches;
  int unsigned  idle_pct;
  bit           start_hi;   // value last scheduled on start

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs
  initial begin
    #(8 * 1000000);
    $display("FAILURE");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Stream end in bits; lengths above the buffer size clamp to it.
  function automatic int unsigned usable_bits();
    return ((cur_length > BUF_BYTES) ? BUF_BYTES : cur_length) * 8;
  endfunction

  // MSB-first bit fetch from the shadow buffer.
  function automatic bit stream_bit(int unsigned addr);
    int unsigned idx;
    idx = addr >> 3;
    if (idx >= BUF_BYTES) return 1'b0;
    return shadow_bytes[idx][7 - (addr & 7)];
  endfunction

  function automatic logic [31:0] stream_bits(int unsigned addr, int unsigned n);
    logic [31:0] v;
    v = '0;
    for (int unsigned i = 0; i < n; i++) v = {v[30:0], stream_bit(addr + i)};
    return v;
  endfunction

  // Expected result of one accepted command; advances the shadow state.
  function automatic outcome_t predict_outcome(cmd_t c);
    outcome_t    o;
    int unsigned pos, stop, npos, zeros, total, seek_to;
    int          skip_to;
    bit          found;
    pos           = cur_pos;
    stop          = usable_bits();
    npos          = pos;
    o.value       = '0;
    o.code_length = '0;
    o.status      = ST_OK;
    case (c.func)
      FN_LOAD: begin
        // 12-bit address always lands inside the 4096-byte buffer
        shadow_bytes[c.load_address] = c.load_data;
        byte_loaded[c.load_address]  = 1'b1;
      end
      FN_READ, FN_PEEK: begin
        if (c.bit_count > MAX_BITS) o.status = ST_BAD;
        else if (pos + c.bit_count > stop) o.status = ST_END;
        else begin
          o.value = stream_bits(pos, c.bit_count);
          if (c.func == FN_READ) npos = pos + c.bit_count;
        end
      end
      FN_READ_UE, FN_PEEK_UE: begin
        zeros = 0;
        found = 1'b0;
        // count leading zeros; running off the stream beats a long prefix
        while (zeros <= UE_ZERO_LIMIT) begin
          if (pos + zeros >= stop) begin
            o.status = ST_END;
            break;
          end
          if (stream_bit(pos + zeros)) begin
            found = 1'b1;
            break;
          end
          zeros++;
        end
        if (!found && o.status == ST_OK) o.status = ST_BAD;
        if (found) begin
          total = 2 * zeros + 1;
          if (pos + total > stop) o.status = ST_END;
          else begin
            o.value       = ((32'd1 << zeros) - 32'd1) + stream_bits(pos + zeros + 1, zeros);
            o.code_length = ClenW'(total);
            if (c.func == FN_READ_UE) npos = pos + total;
          end
        end
      end
      FN_SEEK: begin
        seek_to = c.seek_byte * 8 + c.seek_bit;
        if (seek_to > stop) o.status = ST_END;
        else npos = seek_to;
      end
      FN_SKIP: begin
        // bit-address arithmetic, so a backward skip never leaves a negative bit index
        skip_to = int'(pos) + int'(c.bit_offset);
        if (skip_to < 0 || skip_to > int'(stop)) o.status = ST_END;
        else npos = int'(skip_to);
      end
      default: o.status = ST_BAD;
    endcase
    cur_pos         = npos;
    o.position_byte = LenW'(npos >> 3);
    o.position_bit  = BitW'(npos);
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking: done_o is sampled mid-cycle, away from the driving edge
  // ---------------------------------------------------------------------------

  task automatic flag_mismatch(string what);
    if (mismatches < 50) $display("[%0t] mismatch: %s", $time, what);
    mismatches++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) flag_mismatch($sformatf("%s got %0h, want %0h", name, got, want));
  endtask

  always @(negedge clk_i) begin
    if (rst_ni && done_o) begin
      if (expected_outcomes.size() == 0) flag_mismatch("result transfer with nothing pending");
      else begin
        oldest = expected_outcomes.pop_front();
        check_field("value", value_o, oldest.value);
        check_field("code_length", code_length_o, oldest.code_length);
        check_field("status", status_o, oldest.status);
        check_field("position_byte", position_byte_o, oldest.position_byte);
        check_field("position_bit", position_bit_o, oldest.position_bit);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driving. Every send returns right after its accepting edge with start
  // still high; the caller either sends again in the same step or calls
  // stop_sending, so start never gets two updates in one step.
  // ---------------------------------------------------------------------------

  task automatic send_command(cmd_t c);
    bit taken;
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      if (start_hi) begin
        start    <= 1'b0;
        start_hi  = 1'b0;
      end
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    start          <= 1'b1;
    start_hi        = 1'b1;
    func_i         <= c.func;
    load_address_i <= c.load_address;
    load_data_i    <= c.load_data;
    bit_count_i    <= c.bit_count;
    seek_byte_i    <= c.seek_byte;
    seek_bit_i     <= c.seek_bit;
    bit_offset_i   <= c.bit_offset;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = !busy;
      @(posedge clk_i);
    end
    expected_outcomes.push_back(predict_outcome(c));
  endtask

  task automatic stop_sending();
    if (start_hi) begin
      start    <= 1'b0;
      start_hi  = 1'b0;
    end
  endtask

  // All fields random so every input bit toggles; callers shape what matters.
  function automatic cmd_t random_fields(logic [FuncW-1:0] f);
    cmd_t c;
    c.func         = f;
    c.load_address = LAddrW'($urandom);
    c.load_data    = DataW'($urandom);
    c.bit_count    = CountW'($urandom);
    c.seek_byte    = LenW'($urandom);
    c.seek_bit     = BitW'($urandom);
    c.bit_offset   = OffW'($urandom);
    return c;
  endfunction

  // Zero-heavy bytes so ue prefixes get long
  function automatic logic [7:0] pick_stream_byte();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 30) return 8'h00;
    if (r < 40) return 8'h01 << $urandom_range(0, 7);
    return 8'($urandom);
  endfunction

  // Never let the block touch a buffer byte that was never written: load
  // every missing byte a read or ue scan could reach from here.
  task automatic load_read_window();
    cmd_t        c;
    int unsigned first;
    first = cur_pos >> 3;
    for (int unsigned b = first; b < first + WINDOW_BYTES && b < BUF_BYTES; b++) begin
      if (!byte_loaded[b]) begin
        c = random_fields(FN_LOAD);
        c.load_address = LAddrW'(b);
        c.load_data    = pick_stream_byte();
        send_command(c);
      end
    end
  endtask

  task automatic issue(cmd_t c);
    if (c.func inside {FN_READ, FN_PEEK, FN_READ_UE, FN_PEEK_UE}) load_read_window();
    send_command(c);
  endtask

  task automatic do_load(int unsigned addr, logic [7:0] data);
    cmd_t c;
    c = random_fields(FN_LOAD);
    c.load_address = LAddrW'(addr);
    c.load_data    = data;
    issue(c);
  endtask

  task automatic do_read(logic [FuncW-1:0] f, int unsigned count);
    cmd_t c;
    c = random_fields(f);
    c.bit_count = CountW'(count);
    issue(c);
  endtask

  task automatic do_seek(int unsigned byte_idx, int unsigned bit_idx);
    cmd_t c;
    c = random_fields(FN_SEEK);
    c.seek_byte = LenW'(byte_idx);
    c.seek_bit  = BitW'(bit_idx);
    issue(c);
  endtask

  task automatic do_skip(int offset);
    cmd_t c;
    c = random_fields(FN_SKIP);
    c.bit_offset = OffW'(offset);
    issue(c);
  endtask

  // Register writes only with nothing in flight
  task automatic write_stream_length(int unsigned len);
    stop_sending();
    while (expected_outcomes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= LenW'(len);
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    cur_length  = len;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Right after reset: length 0, position 0
  task automatic test_empty_stream();
    cmd_t c;
    c = random_fields(FN_UNUSED);
    issue(c);                        // unknown func: malformed
    // byte 0 = one bit then zeros, bytes 1..4 zero, byte 5 all ones
    do_load(0, 8'h80);
    for (int unsigned b = 1; b <= 4; b++) do_load(b, 8'h00);
    do_load(5, 8'hFF);
    do_load(BUF_BYTES - 1, 8'hFF);   // top of the buffer
    do_read(FN_READ, 0);             // zero bits: fine even on an empty stream
    do_read(FN_PEEK_UE, 0);          // nothing to scan: past end
    do_skip(-1);                     // below zero
    do_seek(0, 1);                   // past a zero-length stream
    do_seek(0, 0);
  endtask

  task automatic test_reads_and_codes();
    write_stream_length(8);
    do_read(FN_PEEK_UE, 0);          // single one bit: value 0, length 1
    do_read(FN_READ_UE, 0);
    do_read(FN_PEEK_UE, 0);          // 39 leading zeros: prefix too long
    do_read(FN_READ, MAX_BITS);      // widest read
    do_read(FN_PEEK, MAX_BITS + 1);  // too many bits
    do_read(FN_READ, 63);
    do_seek(4, 7);
    do_read(FN_READ_UE, 0);          // "011": value 2, length 3
  endtask

  task automatic test_position_moves();
    do_seek(8, 0);                   // exactly at the end is legal
    do_read(FN_READ, 1);             // past end
    do_read(FN_READ_UE, 0);          // ue out of stream
    do_seek(8, 1);                   // end byte with nonzero bit
    do_seek((1 << LenW) - 1, 7);
    do_skip(-32768);
    do_skip(32767);
    do_skip(-64);                    // back to the start
  endtask

  function automatic int unsigned pick_stream_length(int unsigned phase, int unsigned round);
    case (phase)
      0:       return 0;
      1:       return 1;
      2:       return (round == 1) ? (1 << LenW) - 1 : BUF_BYTES;
      7:       return $urandom_range(64, 1024);
      default: return $urandom_range(2, 40);
    endcase
  endfunction

  function automatic cmd_t random_command();
    cmd_t        c;
    int unsigned r, stop, hi, target;
    int          diff;
    stop = usable_bits();
    r    = $urandom_range(0, 99);
    if      (r < 14) c = random_fields(FN_LOAD);
    else if (r < 32) c = random_fields(FN_READ);
    else if (r < 42) c = random_fields(FN_PEEK);
    else if (r < 60) c = random_fields(FN_READ_UE);
    else if (r < 70) c = random_fields(FN_PEEK_UE);
    else if (r < 82) c = random_fields(FN_SEEK);
    else if (r < 97) c = random_fields(FN_SKIP);
    else             c = random_fields(FN_UNUSED);
    case (c.func)
      FN_LOAD: begin
        hi = stop / 8 + 8;
        if (hi > BUF_BYTES - 1) hi = BUF_BYTES - 1;
        if ($urandom_range(0, 9) < 7) c.load_address = LAddrW'($urandom_range(0, hi));
        c.load_data = pick_stream_byte();
      end
      FN_READ, FN_PEEK: begin
        if ($urandom_range(0, 99) < 85) c.bit_count = CountW'($urandom_range(0, MAX_BITS));
        else c.bit_count = CountW'($urandom_range(MAX_BITS + 1, 63));
      end
      FN_SEEK: begin
        // mostly land inside the stream, else the raw random target
        if ($urandom_range(0, 99) < 75) begin
          target      = $urandom_range(0, stop);
          c.seek_byte = LenW'(target >> 3);
          c.seek_bit  = BitW'(target);
        end
      end
      FN_SKIP: begin
        if ($urandom_range(0, 99) < 75) begin
          diff = int'($urandom_range(0, stop)) - int'(cur_pos);
          if (diff > 32767) diff = 32767;
          c.bit_offset = OffW'(diff);
        end
      end
      default: ;
    endcase
    return c;
  endfunction

  // Phases of random traffic, each under its own stream_length
  task automatic test_random_commands(int unsigned round);
    for (int unsigned p = 0; p < PHASES; p++) begin
      write_stream_length(pick_stream_length(p, round));
      for (int unsigned k = 0; k < PHASE_ITEMS; k++) issue(random_command());
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = '0;
    start          = 1'b0;
    func_i         = FN_LOAD;
    load_address_i = '0;
    load_data_i    = '0;
    bit_count_i    = '0;
    seek_byte_i    = '0;
    seek_bit_i     = '0;
    bit_offset_i   = '0;
    start_hi       = 1'b0;
    mismatches     = 0;
    cur_pos        = 0;
    cur_length     = 0;
    for (int unsigned b = 0; b < BUF_BYTES; b++) begin
      shadow_bytes[b] = 8'h00;
      byte_loaded[b]  = 1'b0;
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    idle_pct = 38;
    test_empty_stream();
    test_reads_and_codes();
    test_position_moves();
    test_random_commands(0);
    idle_pct = 45;
    test_random_commands(1);
    idle_pct = 0;                    // back-to-back transfers
    test_random_commands(2);

    stop_sending();
    while (expected_outcomes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+sv
sv/bsr_pkg.sv
sv/bsr_ram.sv
sv/bitstream_reader_expgolomb.sv
tb/tb.sv
